// ===== rtl/bpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Bucketed priority pool package
// Sizes, request and status codes, and the records passed between the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bpp_pkg;

    localparam int CAPACITY = 64;
    localparam int BUCKETS  = 64;
    localparam int KEY_BITS = 64;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int BKT_W  = 6;
    localparam int PRI_W  = 64;
    localparam int AGE_W  = 32;
    localparam int FILL_W = 7;
    localparam int CFG_W  = 7;
    localparam int KEY_W  = 64;
    localparam int CMP_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    localparam logic [2:0] REQ_PUSH     = 3'd0;
    localparam logic [2:0] REQ_POP      = 3'd1;
    localparam logic [2:0] REQ_TOP      = 3'd2;
    localparam logic [2:0] REQ_ERASE    = 3'd3;
    localparam logic [2:0] REQ_CONTAINS = 3'd4;
    localparam logic [2:0] REQ_CLEAR    = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_EVICTED = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic CFG_POOL_LIMIT = 1'b0;
    localparam logic CFG_RESERVED   = 1'b1;

    // Request as seen by every cell during a sweep.
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [BKT_W-1:0]    bkt;
        logic [AGE_W-1:0]    ctr;
    } t_req;

    // Update broadcast to the cells when a request completes.
    typedef struct packed {
        logic                wr;
        logic [IDX_W-1:0]    wr_idx;
        logic [KEY_BITS-1:0] key;
        logic [BKT_W-1:0]    bkt;
        logic [PRI_W-1:0]    pri;
        logic [AGE_W-1:0]    age;
        logic                clr;
        logic [IDX_W-1:0]    clr_idx;
        logic                clr_all;
    } t_cmd;

    // Partial search result handed from one cell to the next.
    typedef struct packed {
        logic                found;
        logic [IDX_W-1:0]    f_idx;
        logic [BKT_W-1:0]    f_bkt;
        logic [PRI_W-1:0]    f_pri;
        logic                free;
        logic [IDX_W-1:0]    fr_idx;
        logic [CNT_W-1:0]    tot;
        logic [CNT_W-1:0]    bcnt;
        logic                bv;
        logic [IDX_W-1:0]    b_idx;
        logic [KEY_BITS-1:0] b_key;
        logic [PRI_W-1:0]    b_pri;
        logic [AGE_W-1:0]    b_dist;
        logic                wv;
        logic [IDX_W-1:0]    w_idx;
        logic [KEY_BITS-1:0] w_key;
        logic [PRI_W-1:0]    w_pri;
        logic [AGE_W-1:0]    w_dist;
    } t_wave;

    function automatic logic [BKT_W-1:0] bucket_of(input logic [BKT_W-1:0] raw);
        return BKT_W'(raw % BUCKETS);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bpp_if.sv =====
// ----------------------------------------------------------------------------
// Bucketed priority pool channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [63:0] entry_key;
    logic [5:0]  bucket_id;
    logic [63:0] entry_priority;

    modport source (output valid, req_type, entry_key, bucket_id, entry_priority,
                    input ready);
    modport sink (input valid, req_type, entry_key, bucket_id, entry_priority,
                  output ready);
endinterface

interface bpp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] out_key;
    logic [5:0]  out_bucket;
    logic [63:0] out_priority;
    logic        evicted_valid;
    logic [63:0] evicted_key;
    logic [6:0]  bucket_fill;
    logic [6:0]  total_fill;

    modport source (output valid, status, out_key, out_bucket, out_priority,
                    evicted_valid, evicted_key, bucket_fill, total_fill,
                    input ready);
    modport sink (input valid, status, out_key, out_bucket, out_priority,
                  evicted_valid, evicted_key, bucket_fill, total_fill,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/bucketed_priority_pool_top.sv =====
// ----------------------------------------------------------------------------
// Bucketed priority pool
// Pool of keyed, bucketed, prioritized entries held in a chain of slot cells.
// ----------------------------------------------------------------------------
// The result item of a request is registered once the search record has crossed
// the chain of CAPACITY slot cells, moving one slot cell per cycle, and the
// slots are updated in the cycle the result is registered. A new request is
// taken after that, once the controller is back in its idle state.
// One request is in flight at a time; the next one may be accepted while the
// previous result is still waiting, but its result is held back until the sink
// takes the earlier one.
`default_nettype none

module bucketed_priority_pool_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [6:0] i_cfg_data,
    bpp_in_if.sink          in_ch,
    bpp_out_if.source       out_ch
);
    import bpp_pkg::*;

    t_req  req;
    t_cmd  cmd;
    t_wave wave [CAPACITY+1];

    assign wave[0] = '0;

    bpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_wave     (wave[CAPACITY]),
        .o_req      (req),
        .o_cmd      (cmd)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bpp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_req   (req),
            .i_cmd   (cmd),
            .i_wave  (wave[g]),
            .o_wave  (wave[g+1])
        );
    end

endmodule

`default_nettype wire

// ===== rtl/bpp_cell.sv =====
// ----------------------------------------------------------------------------
// Bucketed priority pool cell
// Holds one slot and folds it into the search record passed down the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [bpp_pkg::IDX_W-1:0] i_idx,
    input  wire bpp_pkg::t_req            i_req,
    input  wire bpp_pkg::t_cmd            i_cmd,
    input  wire bpp_pkg::t_wave           i_wave,
    output bpp_pkg::t_wave                o_wave
);
    import bpp_pkg::*;

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [BKT_W-1:0]    r_bkt;
    logic [PRI_W-1:0]    r_pri;
    logic [AGE_W-1:0]    r_age;
    t_wave               r_wave;
    t_wave               n_wave;
    logic                hit;
    logic                inb;
    logic [AGE_W-1:0]    age_dist;

    always_comb begin
        hit      = r_valid && (r_key == i_req.key);
        inb      = r_valid && (r_bkt == i_req.bkt);
        age_dist = i_req.ctr - r_age;
        n_wave   = i_wave;
        if (hit && !i_wave.found) begin
            n_wave.found = 1'b1;
            n_wave.f_idx = i_idx;
            n_wave.f_bkt = r_bkt;
            n_wave.f_pri = r_pri;
        end
        if (!r_valid && !i_wave.free) begin
            n_wave.free   = 1'b1;
            n_wave.fr_idx = i_idx;
        end
        if (r_valid) begin
            n_wave.tot = i_wave.tot + CNT_W'(1);
        end
        if (inb) begin
            n_wave.bcnt = i_wave.bcnt + CNT_W'(1);
        end
        // Best: lowest priority, the oldest among equals.
        if (inb && (!i_wave.bv || (r_pri < i_wave.b_pri) ||
                    ((r_pri == i_wave.b_pri) && (age_dist > i_wave.b_dist)))) begin
            n_wave.bv     = 1'b1;
            n_wave.b_idx  = i_idx;
            n_wave.b_key  = r_key;
            n_wave.b_pri  = r_pri;
            n_wave.b_dist = age_dist;
        end
        // Worst: highest priority, the newest among equals.
        if (inb && (!i_wave.wv || (r_pri > i_wave.w_pri) ||
                    ((r_pri == i_wave.w_pri) && (age_dist < i_wave.w_dist)))) begin
            n_wave.wv     = 1'b1;
            n_wave.w_idx  = i_idx;
            n_wave.w_key  = r_key;
            n_wave.w_pri  = r_pri;
            n_wave.w_dist = age_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clr_all) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr && (i_cmd.wr_idx == i_idx)) begin
            r_valid <= 1'b1;
        end else if (i_cmd.clr && (i_cmd.clr_idx == i_idx)) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wave <= n_wave;
        if (i_cmd.wr && (i_cmd.wr_idx == i_idx)) begin
            r_key <= i_cmd.key;
            r_bkt <= i_cmd.bkt;
            r_pri <= i_cmd.pri;
            r_age <= i_cmd.age;
        end
    end

    assign o_wave = r_wave;

endmodule

`default_nettype wire

// ===== rtl/bpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bucketed priority pool controller
// Takes requests, waits for the search to cross the chain, then updates the
// slots and registers the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [6:0]            i_cfg_data,
    bpp_in_if.sink                     in_ch,
    bpp_out_if.source                  out_ch,
    input  wire bpp_pkg::t_wave        i_wave,
    output bpp_pkg::t_req              o_req,
    output bpp_pkg::t_cmd              o_cmd
);
    import bpp_pkg::*;

    typedef enum logic {S_IDLE, S_SWEEP} t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [CFG_W-1:0]    r_limit;
    logic [CFG_W-1:0]    r_reserved;
    logic [AGE_W-1:0]    r_ctr;
    logic [2:0]          r_type;
    logic [KEY_BITS-1:0] r_key;
    logic [BKT_W-1:0]    r_bkt;
    logic [PRI_W-1:0]    r_pri;

    logic                r_out_valid;
    logic [2:0]          r_status;
    logic [KEY_W-1:0]    r_out_key;
    logic [BKT_W-1:0]    r_out_bkt;
    logic [PRI_W-1:0]    r_out_pri;
    logic                r_ev_valid;
    logic [KEY_W-1:0]    r_ev_key;
    logic [FILL_W-1:0]   r_bfill;
    logic [FILL_W-1:0]   r_tfill;

    logic                finish;
    logic                bump;
    logic [2:0]          n_status;
    logic [KEY_W-1:0]    n_out_key;
    logic [BKT_W-1:0]    n_out_bkt;
    logic [PRI_W-1:0]    n_out_pri;
    logic                n_ev_valid;
    logic [KEY_W-1:0]    n_ev_key;
    logic [CNT_W-1:0]    n_bcnt;
    logic [CNT_W-1:0]    n_tot;
    logic [CMP_W-1:0]    tot1;
    logic [CMP_W-1:0]    bc1;
    logic                evict;
    logic                new_worst;

    assign finish = (r_state == S_SWEEP) && (r_cnt == CNT_W'(CAPACITY)) &&
                    (!r_out_valid || out_ch.ready);

    always_comb begin
        tot1       = CMP_W'(i_wave.tot) + CMP_W'(1);
        bc1        = CMP_W'(i_wave.bcnt) + CMP_W'(1);
        evict      = (tot1 > CMP_W'(r_limit)) && (bc1 > CMP_W'(r_reserved));
        // The new entry sits one step back from the counter. It loses a priority
        // tie to anything older; at an equal age the lower slot counts as worse.
        new_worst  = !i_wave.wv || (r_pri > i_wave.w_pri) ||
                     ((r_pri == i_wave.w_pri) &&
                      ((i_wave.w_dist > AGE_W'(1)) ||
                       ((i_wave.w_dist == AGE_W'(1)) && (i_wave.fr_idx < i_wave.w_idx))));
        n_status   = ST_OK;
        n_out_key  = '0;
        n_out_bkt  = '0;
        n_out_pri  = '0;
        n_ev_valid = 1'b0;
        n_ev_key   = '0;
        n_bcnt     = i_wave.bcnt;
        n_tot      = i_wave.tot;
        bump       = 1'b0;
        o_cmd      = '0;
        o_cmd.key  = r_key;
        o_cmd.bkt  = r_bkt;
        o_cmd.pri  = r_pri;
        o_cmd.age  = r_ctr;
        o_cmd.wr_idx = i_wave.fr_idx;
        case (r_type)
            REQ_PUSH: begin
                if (i_wave.found) begin
                    n_status = ST_DUP;
                end else if (!i_wave.free) begin
                    n_status = ST_FULL;
                end else begin
                    bump = 1'b1;
                    if (evict && new_worst) begin
                        n_status = ST_EVICTED;
                    end else if (evict) begin
                        o_cmd.wr      = 1'b1;
                        o_cmd.clr     = 1'b1;
                        o_cmd.clr_idx = i_wave.w_idx;
                        n_ev_valid    = 1'b1;
                        n_ev_key      = KEY_W'(i_wave.w_key);
                    end else begin
                        o_cmd.wr = 1'b1;
                        n_bcnt   = i_wave.bcnt + CNT_W'(1);
                        n_tot    = i_wave.tot + CNT_W'(1);
                    end
                end
            end
            REQ_POP, REQ_TOP: begin
                if (!i_wave.bv) begin
                    n_status = ST_MISSING;
                end else begin
                    n_out_key = KEY_W'(i_wave.b_key);
                    n_out_bkt = r_bkt;
                    n_out_pri = i_wave.b_pri;
                    if (r_type == REQ_POP) begin
                        o_cmd.clr     = 1'b1;
                        o_cmd.clr_idx = i_wave.b_idx;
                        n_bcnt        = i_wave.bcnt - CNT_W'(1);
                        n_tot         = i_wave.tot - CNT_W'(1);
                    end
                end
            end
            REQ_ERASE, REQ_CONTAINS: begin
                if (!i_wave.found) begin
                    n_status = ST_MISSING;
                end else begin
                    n_out_key = KEY_W'(r_key);
                    n_out_bkt = i_wave.f_bkt;
                    n_out_pri = i_wave.f_pri;
                    if (r_type == REQ_ERASE) begin
                        o_cmd.clr     = 1'b1;
                        o_cmd.clr_idx = i_wave.f_idx;
                        n_tot         = i_wave.tot - CNT_W'(1);
                        if (i_wave.f_bkt == r_bkt) begin
                            n_bcnt = i_wave.bcnt - CNT_W'(1);
                        end
                    end
                end
            end
            REQ_CLEAR: begin
                o_cmd.clr_all = 1'b1;
                n_bcnt        = '0;
                n_tot         = '0;
            end
            default: begin
            end
        endcase
        if (!finish) begin
            o_cmd.wr      = 1'b0;
            o_cmd.clr     = 1'b0;
            o_cmd.clr_all = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_limit     <= CFG_W'(64);
            r_reserved  <= '0;
            r_ctr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_POOL_LIMIT)) begin
                r_limit <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_RESERVED)) begin
                r_reserved <= i_cfg_data;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_state <= S_SWEEP;
                        r_cnt   <= '0;
                    end
                end
                S_SWEEP: begin
                    if (r_cnt != CNT_W'(CAPACITY)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end else if (finish) begin
                        r_state <= S_IDLE;
                        if (bump) begin
                            r_ctr <= r_ctr + AGE_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && in_ch.valid) begin
            r_type <= in_ch.req_type;
            r_key  <= KEY_BITS'(in_ch.entry_key);
            r_bkt  <= bucket_of(in_ch.bucket_id);
            r_pri  <= in_ch.entry_priority;
        end
        if (finish) begin
            r_status   <= n_status;
            r_out_key  <= n_out_key;
            r_out_bkt  <= n_out_bkt;
            r_out_pri  <= n_out_pri;
            r_ev_valid <= n_ev_valid;
            r_ev_key   <= n_ev_key;
            r_bfill    <= FILL_W'(n_bcnt);
            r_tfill    <= FILL_W'(n_tot);
        end
    end

    assign in_ch.ready          = (r_state == S_IDLE);
    assign out_ch.valid         = r_out_valid;
    assign out_ch.status        = r_status;
    assign out_ch.out_key       = r_out_key;
    assign out_ch.out_bucket    = r_out_bkt;
    assign out_ch.out_priority  = r_out_pri;
    assign out_ch.evicted_valid = r_ev_valid;
    assign out_ch.evicted_key   = r_ev_key;
    assign out_ch.bucket_fill   = r_bfill;
    assign out_ch.total_fill    = r_tfill;

    // A push ranks ages against the counter as it stands after the push.
    assign o_req.key = r_key;
    assign o_req.bkt = r_bkt;
    assign o_req.ctr = (r_type == REQ_PUSH) ? (r_ctr + AGE_W'(1)) : r_ctr;

endmodule

`default_nettype wire

// ===== rtl/bpp_chk.sv =====
// ----------------------------------------------------------------------------
// Bucketed priority pool checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_status,
    input wire logic [6:0] i_bucket_fill,
    input wire logic [6:0] i_total_fill
);
    import bpp_pkg::*;

    // A waiting result item holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped before it was taken");

    // Only one request is worked on at a time.
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while another is in progress");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= ST_FULL)
        else $error("status code out of range");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_bucket_fill <= i_total_fill) && (i_total_fill <= 7'd64))
        else $error("fill counts inconsistent");

endmodule

bind bucketed_priority_pool_top bpp_chk u_bpp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (in_ch.valid),
    .i_in_ready    (in_ch.ready),
    .i_out_valid   (out_ch.valid),
    .i_out_ready   (out_ch.ready),
    .i_status      (out_ch.status),
    .i_bucket_fill (out_ch.bucket_fill),
    .i_total_fill  (out_ch.total_fill)
);

`default_nettype wire

// ===== dv/bpp_checker.sv =====
// ----------------------------------------------------------------------------
// Bucketed priority pool checker
// Watches the request and result channels, keeps its own copy of the pool,
// predicts each result item and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bpp_checker
    import bpp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [6:0] i_cfg_data,
    bpp_in_if               in_ch,
    bpp_out_if              out_ch,
    output int              o_fail_count,
    output int              o_pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_key;
        logic [5:0]  out_bucket;
        logic [63:0] out_priority;
        logic        evicted_valid;
        logic [63:0] evicted_key;
        logic [6:0]  bucket_fill;
        logic [6:0]  total_fill;
    } t_result;

    bit          pool_used [CAPACITY];
    bit [63:0]   pool_key  [CAPACITY];
    bit [5:0]    pool_bkt  [CAPACITY];
    bit [63:0]   pool_pri  [CAPACITY];
    bit [31:0]   pool_age  [CAPACITY];
    bit [31:0]   push_count;
    int          fill_of_bucket [BUCKETS];
    int          limit_reg;
    int          reserved_reg;
    t_result     expected_results [$];

    assign o_pending = expected_results.size();

    function automatic int find_key(bit [63:0] key);
        for (int i = 0; i < CAPACITY; i++)
            if (pool_used[i] && pool_key[i] == key) return i;
        return -1;
    endfunction

    function automatic int pool_total();
        int n;
        n = 0;
        for (int i = 0; i < CAPACITY; i++) n += pool_used[i];
        return n;
    endfunction

    // a was inserted before b, measured as modular distance back from the counter
    function automatic bit older(int a, int b);
        return (push_count - pool_age[a]) > (push_count - pool_age[b]);
    endfunction

    function automatic int bucket_extreme(bit [5:0] b, bit worst);
        int sel;
        bit take;
        sel = -1;
        for (int i = 0; i < CAPACITY; i++) begin
            if (!pool_used[i] || pool_bkt[i] != b) continue;
            if (sel < 0) begin
                sel = i;
                continue;
            end
            if (worst)
                take = pool_pri[i] > pool_pri[sel] ||
                       (pool_pri[i] == pool_pri[sel] && older(sel, i));
            else
                take = pool_pri[i] < pool_pri[sel] ||
                       (pool_pri[i] == pool_pri[sel] && older(i, sel));
            if (take) sel = i;
        end
        return sel;
    endfunction

    function automatic void drop_slot(int i);
        pool_used[i] = 0;
        if (fill_of_bucket[pool_bkt[i]] > 0) fill_of_bucket[pool_bkt[i]]--;
    endfunction

    function automatic t_result predict_request(bit [2:0] req, bit [63:0] key,
                                                bit [5:0] b, bit [63:0] pri);
        t_result r;
        int i, w;
        r = '0;
        case (req)
            REQ_PUSH: begin
                if (find_key(key) >= 0) begin
                    r.status = ST_DUP;
                end else begin
                    for (i = 0; i < CAPACITY && pool_used[i]; i++) ;
                    if (i >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        pool_used[i] = 1;
                        pool_key[i]  = key;
                        pool_bkt[i]  = b;
                        pool_pri[i]  = pri;
                        pool_age[i]  = push_count;
                        push_count++;
                        fill_of_bucket[b]++;
                        if (pool_total() > limit_reg && fill_of_bucket[b] > reserved_reg) begin
                            w = bucket_extreme(b, 1);
                            if (w == i) begin
                                r.status = ST_EVICTED;
                            end else begin
                                r.evicted_valid = 1;
                                r.evicted_key   = pool_key[w];
                            end
                            drop_slot(w);
                        end
                    end
                end
            end
            REQ_POP, REQ_TOP, REQ_ERASE, REQ_CONTAINS: begin
                if (req == REQ_POP || req == REQ_TOP) i = bucket_extreme(b, 0);
                else i = find_key(key);
                if (i < 0) begin
                    r.status = ST_MISSING;
                end else begin
                    r.out_key      = pool_key[i];
                    r.out_bucket   = pool_bkt[i];
                    r.out_priority = pool_pri[i];
                    if (req == REQ_POP || req == REQ_ERASE) drop_slot(i);
                end
            end
            REQ_CLEAR: begin
                for (int k = 0; k < CAPACITY; k++) pool_used[k] = 0;
                for (int k = 0; k < BUCKETS; k++) fill_of_bucket[k] = 0;
            end
            default: ;
        endcase
        r.bucket_fill = 7'(fill_of_bucket[b]);
        r.total_fill  = 7'(pool_total());
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            for (int k = 0; k < CAPACITY; k++) pool_used[k] = 0;
            for (int k = 0; k < BUCKETS; k++) fill_of_bucket[k] = 0;
            push_count   = 0;
            limit_reg    = 64;
            reserved_reg = 0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_POOL_LIMIT) limit_reg = i_cfg_data;
                else reserved_reg = i_cfg_data;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.status, out_ch.out_key, out_ch.out_bucket,
                        out_ch.out_priority, out_ch.evicted_valid, out_ch.evicted_key,
                        out_ch.bucket_fill, out_ch.total_fill};
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result item: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch\n  expected %p\n  actual   %p", want, got);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(predict_request(in_ch.req_type,
                    in_ch.entry_key, in_ch.bucket_id, in_ch.entry_priority));
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Bucketed priority pool testbench
// Drives directed and random request items in bursts through several register
// settings, stalls the result side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import bpp_pkg::*;

    localparam int CYCLE_LIMIT = 20000;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       cfg_we = 0;
    logic       cfg_idx = 0;
    logic [6:0] cfg_data = 0;
    int         fail_count;
    int         pending;
    int         quiet_cycles = 0;
    bit [63:0]  key_pool [16];

    bpp_in_if  in_ch ();
    bpp_out_if out_ch ();

    bucketed_priority_pool_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    bpp_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    // The receiver stalls in runs; some stretches are never stalled.
    initial begin
        int mode;
        out_ch.ready = 0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200)) begin
                @(negedge i_clk);
                out_ch.ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_request(bit [2:0] req, bit [63:0] key, bit [5:0] b, bit [63:0] pri);
        in_ch.req_type       <= req;
        in_ch.entry_key      <= key;
        in_ch.bucket_id      <= b;
        in_ch.entry_priority <= pri;
        in_ch.valid          <= 1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int cycles);
        in_ch.valid <= 0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_pool();
        in_ch.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_register(bit idx, bit [6:0] value);
        cfg_we   <= 1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 0;
        @(negedge i_clk);
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly keys from a small set so that duplicates, erases and hits occur.
    task automatic random_phase(int count, int bucket_span);
        int sent, burst;
        bit [2:0]  req;
        bit [63:0] pri;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && sent < count) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7: req = REQ_PUSH;
                    8, 9, 10:  req = REQ_POP;
                    11, 12:    req = REQ_TOP;
                    13, 14:    req = REQ_ERASE;
                    15, 16:    req = REQ_CONTAINS;
                    17:        req = ($urandom_range(0, 5) == 0) ? REQ_CLEAR : REQ_PUSH;
                    default:   req = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(6, 7))
                                                                 : REQ_PUSH;
                endcase
                pri = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 3)) : rand64();
                send_request(req,
                    ($urandom_range(0, 3) == 0) ? rand64() : key_pool[$urandom_range(0, 15)],
                    ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, bucket_span)),
                    pri);
                burst--;
                sent++;
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 90));
        end
    endtask

    initial begin
        in_ch.valid          = 0;
        in_ch.req_type       = REQ_PUSH;
        in_ch.entry_key      = 0;
        in_ch.bucket_id      = 0;
        in_ch.entry_priority = 0;
        for (int k = 0; k < 16; k++) key_pool[k] = rand64();
        key_pool[0] = 0;
        key_pool[1] = '1;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: empty pool, extremes, duplicates, ties, eviction, odd codes.
        send_request(REQ_POP, 0, 0, 0);
        send_request(REQ_TOP, 0, 63, 0);
        send_request(REQ_ERASE, 5, 0, 0);
        send_request(REQ_CONTAINS, '1, 0, 0);
        send_request(REQ_PUSH, 0, 0, 0);
        send_request(REQ_PUSH, '1, 63, '1);
        send_request(REQ_PUSH, 0, 7, 9);
        send_request(REQ_PUSH, 64'h55, 63, '1);
        send_request(REQ_TOP, 0, 63, 0);
        send_request(REQ_CONTAINS, '1, 0, 0);
        send_request(3'd6, 1, 63, 1);
        send_request(3'd7, '1, 0, '1);
        send_request(REQ_POP, 0, 63, 0);
        send_request(REQ_ERASE, 0, 0, 0);
        send_request(REQ_CLEAR, 0, 0, 0);
        drain_pool();
        write_register(CFG_POOL_LIMIT, 2);
        write_register(CFG_RESERVED, 0);
        send_request(REQ_PUSH, 1, 3, 10);
        send_request(REQ_PUSH, 2, 3, 10);
        send_request(REQ_PUSH, 3, 3, 10);
        send_request(REQ_PUSH, 4, 3, 99);
        send_request(REQ_PUSH, 5, 3, 1);
        send_request(REQ_POP, 0, 3, 0);
        send_request(REQ_CLEAR, 0, 0, 0);
        drain_pool();

        // Fill to hard capacity with eviction disabled.
        write_register(CFG_POOL_LIMIT, 64);
        for (int k = 0; k < 66; k++) send_request(REQ_PUSH, 64'h1000 + k, 6'(k), rand64());
        send_request(REQ_CLEAR, 0, 0, 0);
        drain_pool();

        write_register(CFG_POOL_LIMIT, 127);
        write_register(CFG_RESERVED, 127);
        random_phase(350, 3);
        drain_pool();
        write_register(CFG_POOL_LIMIT, 0);
        write_register(CFG_RESERVED, 0);
        random_phase(300, 7);
        drain_pool();
        write_register(CFG_POOL_LIMIT, 1);
        write_register(CFG_RESERVED, 64);
        random_phase(250, 63);
        drain_pool();
        write_register(CFG_POOL_LIMIT, 12);
        write_register(CFG_RESERVED, 3);
        random_phase(400, 2);
        drain_pool();
        write_register(CFG_POOL_LIMIT, 40);
        write_register(CFG_RESERVED, 1);
        random_phase(250, 15);
        drain_pool();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
